// ----- hdl/ide_pkg.sv -----
package ide_pkg;

  // Dictionary size and the widths that follow from it.
  localparam int DICT_DEPTH = 256;
  localparam int IDX_W      = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int CNT_W      = $clog2(DICT_DEPTH + 1);

  // The hash table has at least twice as many slots as the dictionary, so it is
  // never more than half full and a probe sequence always ends at a free slot.
  localparam int SLOT_W     = IDX_W + 1;
  localparam int HASH_SLOTS = 2 ** SLOT_W;

  // One table word: occupied flag, dense index, stored value.
  localparam int VAL_W  = 64;
  localparam int WORD_W = 1 + IDX_W + VAL_W;

  // Width of the index field on the result channel.
  localparam int OUT_IDX_W = 8;

  // Folds the 64-bit value onto the slot address by XOR.
  function automatic logic [SLOT_W-1:0] slot_hash(input logic [VAL_W-1:0] v);
    logic [SLOT_W-1:0] h;
    h = '0;
    for (int i = 0; i < VAL_W; i++) begin
      h[i % SLOT_W] = h[i % SLOT_W] ^ v[i];
    end
    return h;
  endfunction

  // Low bits of a dense index, zero-extended where the index is narrower.
  function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] i);
    logic [IDX_W+OUT_IDX_W-1:0] t;
    t = {{OUT_IDX_W{1'b0}}, i};
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

// ----- hdl/integer_dictionary_encoder.sv -----
// Channel  | Direction | Ports                                   | Handshake
// ---------+-----------+-----------------------------------------+-------------------
// input    | in        | in_value[63:0]                          | in_valid/in_ready
// result   | out       | out_dict_index, out_index_valid,        | out_valid/out_ready
//          |           | out_is_new_entry, out_running_max,      |
//          |           | out_dict_overflow                       |
// config   | in        | cfg_dict_disabled                       | cfg_valid/cfg_ready
//
// A word with the dictionary enabled passes the accept, table read and compare steps,
// and table read and compare again for each further probe of the hash table; with it
// disabled, it passes accept and bypass. The table memory's read data is registered.
// After reset a clearing pass marks all HASH_SLOTS table slots free, one a cycle
// (512 slots at the default depth); no word is accepted during it.
// A finished result waits in the output register; a new word is accepted meanwhile,
// and the compare step holds until the output register is free.
module integer_dictionary_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [63:0]                   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ide_pkg::OUT_IDX_W-1:0] out_dict_index,
  output logic                          out_index_valid,
  output logic                          out_is_new_entry,
  output logic [63:0]                   out_running_max,
  output logic                          out_dict_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_dict_disabled
);
  import ide_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_CMP    = 5'b01000,
    ST_BYPASS = 5'b10000
  } state_t;

  // Control state.
  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VAL_W-1:0]   max_r, max_nxt;
  logic               ovf_r, ovf_nxt;
  logic               dis_r, dis_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Word being worked on and its probe position.
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [SLOT_W-1:0]  probe_r, probe_nxt;

  // Result register.
  logic [OUT_IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic                 res_ivld_r, res_ivld_nxt;
  logic                 res_new_r, res_new_nxt;
  logic [VAL_W-1:0]     res_max_r, res_max_nxt;
  logic                 res_ovf_r, res_ovf_nxt;

  // Hash table memory.
  logic [WORD_W-1:0]  table_mem [HASH_SLOTS];
  logic [WORD_W-1:0]  rd_data_r;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  // Fields of the slot just read.
  logic               rd_occ;
  logic [IDX_W-1:0]   rd_idx;
  logic [VAL_W-1:0]   rd_val;
  logic               out_free;
  logic               room;
  logic               insert;
  logic [VAL_W-1:0]   new_max;

  assign rd_occ   = rd_data_r[WORD_W-1];
  assign rd_idx   = rd_data_r[VAL_W +: IDX_W];
  assign rd_val   = rd_data_r[VAL_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign room     = (cnt_r < CNT_W'(DICT_DEPTH));
  assign insert   = (state_r == ST_CMP) && out_free && !rd_occ && room;
  assign new_max  = (val_r > max_r) ? val_r : max_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // The memory is read every cycle at the probe position; writes come from the
  // clearing pass or from an insert.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= table_mem[probe_r];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = probe_r;
    mem_wdata = {1'b1, cnt_r[IDX_W-1:0], val_r};
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (insert) begin
      mem_we = 1'b1;
    end
  end

  // Sequencer: clear, accept, probe, compare and deliver.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    ovf_nxt       = ovf_r;
    dis_nxt       = dis_r;
    out_valid_nxt = out_valid_r;
    val_nxt       = val_r;
    probe_nxt     = probe_r;
    res_idx_nxt   = res_idx_r;
    res_ivld_nxt  = res_ivld_r;
    res_new_nxt   = res_new_r;
    res_max_nxt   = res_max_r;
    res_ovf_nxt   = res_ovf_r;

    if (cfg_valid && cfg_ready) begin
      dis_nxt = cfg_dict_disabled;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {SLOT_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_value;
          probe_nxt = slot_hash(in_value);
          state_nxt = dis_r ? ST_BYPASS : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (rd_occ && rd_val != val_r) begin
          // Slot taken by another value: try the next one.
          probe_nxt = probe_r + 1'b1;
          state_nxt = ST_READ;
        end else if (out_free) begin
          max_nxt       = new_max;
          out_valid_nxt = 1'b1;
          res_max_nxt   = new_max;
          res_new_nxt   = 1'b0;
          res_ivld_nxt  = 1'b0;
          res_idx_nxt   = '0;
          res_ovf_nxt   = ovf_r;
          if (rd_occ) begin
            res_ivld_nxt = 1'b1;
            res_idx_nxt  = out_index(rd_idx);
          end else if (room) begin
            res_ivld_nxt = 1'b1;
            res_new_nxt  = 1'b1;
            res_idx_nxt  = out_index(cnt_r[IDX_W-1:0]);
            cnt_nxt      = cnt_r + 1'b1;
          end else begin
            ovf_nxt     = 1'b1;
            res_ovf_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_BYPASS: begin
        if (out_free) begin
          max_nxt       = new_max;
          out_valid_nxt = 1'b1;
          res_max_nxt   = new_max;
          res_new_nxt   = 1'b0;
          res_ivld_nxt  = 1'b0;
          res_idx_nxt   = '0;
          res_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      max_r       <= '0;
      ovf_r       <= 1'b0;
      dis_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      dis_r       <= dis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    probe_r    <= probe_nxt;
    res_idx_r  <= res_idx_nxt;
    res_ivld_r <= res_ivld_nxt;
    res_new_r  <= res_new_nxt;
    res_max_r  <= res_max_nxt;
    res_ovf_r  <= res_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_dict_index    = res_idx_r;
  assign out_index_valid   = res_ivld_r;
  assign out_is_new_entry  = res_new_r;
  assign out_running_max   = res_max_r;
  assign out_dict_overflow = res_ovf_r;

  // The entry count never passes the dictionary size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DICT_DEPTH))
    else $error("dictionary entry count exceeds its depth");

  // An insert adds exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    insert |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not advance the entry count by one");

  // Once set, the overflow flag stays set until reset.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  // A new entry always carries a valid index.
  a_new_has_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_new_r |-> res_ivld_r)
    else $error("new entry reported without a valid index");

endmodule
